// File: hw/rtl/bsa_pkg.sv
// Shared types and constants of the bitmap slab allocator.
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int MAP_W       = 64;  // bits in one occupancy bitmap
  localparam int POOL_SLOTS  = 3;   // pools that have storage
  localparam int POOL_W      = 2;   // bits to index a stored pool
  localparam int HPOOL_W     = 4;   // pool field of a handle or request
  localparam int CNT_W       = 6;   // run length field of a handle
  localparam int IDX_W       = 6;   // block index field of a handle
  localparam int LIMIT_W     = 7;   // block count register
  localparam int BSIZE_W     = 8;   // block size register
  localparam int SIZE_W      = 16;  // request size
  localparam int HANDLE_W    = 16;
  localparam int HPOOL_LSB   = 12;
  localparam int CNT_LSB     = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [BSIZE_W-1:0] BSIZE_RST [POOL_SLOTS] = '{8'd16, 8'd32, 8'd64};
  localparam logic [LIMIT_W-1:0] BCOUNT_RST [POOL_SLOTS] = '{7'd64, 7'd64, 7'd32};

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_LARGE   = 3'd2,
    ST_NOSPACE = 3'd3,
    ST_BADPOOL = 3'd4
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P0_SIZE  = 3'd0,
    CFG_P1_SIZE  = 3'd1,
    CFG_P2_SIZE  = 3'd2,
    CFG_P0_COUNT = 3'd3,
    CFG_P1_COUNT = 3'd4,
    CFG_P2_COUNT = 3'd5
  } cfg_reg_e;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    cmd_e                 cmd;
    status_e              status;  // outcome of the checks made up front
    logic [POOL_W-1:0]    pool;
    logic [CNT_W-1:0]     count;   // run length in blocks
    logic [IDX_W-1:0]     index;   // first block of a free
    logic [LIMIT_W-1:0]   limit;   // usable blocks of the pool
  } entry_t;

endpackage

// File: hw/rtl/bitmap_slab_allocator_unit.sv
// Bitmap slab allocator: a request channel, a result channel and a config port.
//
// Requests come in on in_valid_i/in_ready_o: cmd_i selects allocate or free.
// An allocate names a pool and a byte size; a free names a handle
// (pool 15:12, run length 11:6, first block 5:0). Every request yields one
// result on out_valid_o/out_ready_i: a status, the granted handle and the
// bitmap of the addressed pool after the request.
// An accepted request passes through the queue, the search registers and the
// result register before its result shows. The back end takes a new request
// only once the previous one has written its bitmap back: a search step reads
// the pool bitmap and scans all start positions in parallel, then an update
// step picks the lowest fit and writes the bitmap back before the next scan
// may begin. Reset clears all three bitmaps at once and loads the default
// block sizes and counts. When the receiver stalls, the result register holds,
// the back end waits, and the two-entry queue keeps taking requests until it
// is full; then in_ready_o drops. The user must write configuration through
// cfg_we_i only while no request is in flight; the block does not enforce it.
`timescale 1ns / 1ps

module bitmap_slab_allocator_unit #(
  parameter int NUM_POOLS  = 3,
  parameter int MAX_BLOCKS = 64,
  parameter int MAX_RUN    = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [bsa_pkg::HPOOL_W-1:0]    pool_id_i,
  input  logic [bsa_pkg::SIZE_W-1:0]     request_size_i,
  input  logic [bsa_pkg::HANDLE_W-1:0]   handle_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     status_o,
  output logic [bsa_pkg::HANDLE_W-1:0]   grant_handle_o,
  output logic [bsa_pkg::MAP_W-1:0]      occupancy_o
);

  bsa_pkg::entry_t entry;
  bsa_pkg::entry_t head;
  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  bsa_front #(
    .NUM_POOLS  (NUM_POOLS),
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_RUN    (MAX_RUN)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd_i),
    .pool_id_i      (pool_id_i),
    .request_size_i (request_size_i),
    .handle_i       (handle_i),
    .entry_o        (entry)
  );

  bsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (head)
  );

  bsa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .grant_handle_o (grant_handle_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

// File: hw/rtl/bsa_front.sv
// Front end: configuration registers and classification of incoming items.
`timescale 1ns / 1ps

module bsa_front #(
  parameter int NUM_POOLS  = 3,
  parameter int MAX_BLOCKS = 64,
  parameter int MAX_RUN    = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                cmd_i,
  input  logic [bsa_pkg::HPOOL_W-1:0]         pool_id_i,
  input  logic [bsa_pkg::SIZE_W-1:0]          request_size_i,
  input  logic [bsa_pkg::HANDLE_W-1:0]        handle_i,
  output bsa_pkg::entry_t                     entry_o
);

  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int PROD_W = bsa_pkg::BSIZE_W + RUN_W;

  logic [bsa_pkg::BSIZE_W-1:0] bsize_q  [bsa_pkg::POOL_SLOTS];
  logic [bsa_pkg::LIMIT_W-1:0] bcount_q [bsa_pkg::POOL_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q  <= bsa_pkg::BSIZE_RST;
      bcount_q <= bsa_pkg::BCOUNT_RST;
    end else if (cfg_we_i) begin
      unique case (bsa_pkg::cfg_reg_e'(cfg_index_i))
        bsa_pkg::CFG_P0_SIZE:  bsize_q[0]  <= cfg_wdata_i;
        bsa_pkg::CFG_P1_SIZE:  bsize_q[1]  <= cfg_wdata_i;
        bsa_pkg::CFG_P2_SIZE:  bsize_q[2]  <= cfg_wdata_i;
        bsa_pkg::CFG_P0_COUNT: bcount_q[0] <= cfg_wdata_i[bsa_pkg::LIMIT_W-1:0];
        bsa_pkg::CFG_P1_COUNT: bcount_q[1] <= cfg_wdata_i[bsa_pkg::LIMIT_W-1:0];
        bsa_pkg::CFG_P2_COUNT: bcount_q[2] <= cfg_wdata_i[bsa_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [bsa_pkg::HPOOL_W-1:0] hpool;
  logic [bsa_pkg::HPOOL_W-1:0] sel_pool;
  logic                        pool_ok;
  logic [bsa_pkg::BSIZE_W-1:0] bs;
  logic [bsa_pkg::LIMIT_W-1:0] bcount;
  logic [PROD_W-1:0]           max_bytes;
  logic [MAX_RUN:0]            lt;
  logic [bsa_pkg::CNT_W-1:0]   run_cnt;

  assign hpool    = handle_i[bsa_pkg::HPOOL_LSB +: bsa_pkg::HPOOL_W];
  assign sel_pool = (cmd_i == bsa_pkg::CMD_FREE) ? hpool : pool_id_i;
  assign pool_ok  = (sel_pool < bsa_pkg::HPOOL_W'(NUM_POOLS)) &&
                    (sel_pool < bsa_pkg::HPOOL_W'(bsa_pkg::POOL_SLOTS));

  always_comb begin
    bs     = '0;
    bcount = '0;
    for (int p = 0; p < bsa_pkg::POOL_SLOTS; p++) begin
      if (pool_id_i == bsa_pkg::HPOOL_W'(p)) begin
        bs     = bsize_q[p];
        bcount = bcount_q[p];
      end
    end
  end

  assign max_bytes = PROD_W'(bs) * PROD_W'(MAX_RUN);

  // lt[k] says k blocks are not enough; within range it is a thermometer code,
  // so the run length sits at its single falling edge.
  always_comb begin
    lt          = '0;
    lt[0]       = 1'b1;
    for (int k = 1; k < MAX_RUN; k++) begin
      lt[k] = bsa_pkg::SIZE_W'(PROD_W'(k) * PROD_W'(bs)) < request_size_i;
    end
    run_cnt = '0;
    for (int k = 0; k < MAX_RUN; k++) begin
      if (lt[k] && !lt[k+1]) run_cnt = run_cnt | bsa_pkg::CNT_W'(k + 1);
    end
  end

  always_comb begin
    entry_o.cmd   = bsa_pkg::cmd_e'(cmd_i);
    entry_o.pool  = sel_pool[bsa_pkg::POOL_W-1:0];
    entry_o.index = handle_i[bsa_pkg::IDX_W-1:0];
    entry_o.limit = (bcount > bsa_pkg::LIMIT_W'(MAX_BLOCKS)) ?
                    bsa_pkg::LIMIT_W'(MAX_BLOCKS) : bcount;
    if (cmd_i == bsa_pkg::CMD_FREE) begin
      entry_o.count  = handle_i[bsa_pkg::CNT_LSB +: bsa_pkg::CNT_W];
      entry_o.status = pool_ok ? bsa_pkg::ST_OK : bsa_pkg::ST_BADPOOL;
    end else begin
      entry_o.count = run_cnt;
      if (!pool_ok) begin
        entry_o.status = bsa_pkg::ST_BADPOOL;
      end else if (request_size_i == '0) begin
        entry_o.status = bsa_pkg::ST_ZERO;
      end else if (request_size_i > bsa_pkg::SIZE_W'(max_bytes)) begin
        entry_o.status = bsa_pkg::ST_LARGE;
      end else begin
        entry_o.status = bsa_pkg::ST_OK;
      end
    end
  end

endmodule

// File: hw/rtl/bsa_queue.sv
// Two-entry queue of classified items between the front and the back.
`timescale 1ns / 1ps

module bsa_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bsa_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bsa_pkg::entry_t data_o
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  bsa_pkg::entry_t      mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]       fill_q, fill_d;

  assign full_o  = (fill_q == (PTR_W + 1)'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) fill_d = fill_q + 1'b1;
    if (!push_i && pop_i) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// File: hw/rtl/bsa_back.sv
// Back end: occupancy bitmaps, first-fit search, update and result register.
`timescale 1ns / 1ps

module bsa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  bsa_pkg::entry_t               head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [bsa_pkg::HANDLE_W-1:0]  grant_handle_o,
  output logic [bsa_pkg::MAP_W-1:0]     occupancy_o
);

  localparam int MAP_W = bsa_pkg::MAP_W;
  localparam int SUM_W = bsa_pkg::LIMIT_W + 1;

  function automatic logic [MAP_W-1:0] run_mask(input logic [bsa_pkg::CNT_W-1:0] cnt);
    run_mask = (MAP_W'(1) << cnt) - MAP_W'(1);
  endfunction

  logic [MAP_W-1:0] map_q [bsa_pkg::POOL_SLOTS];

  // Search stage registers.
  logic             s2_valid_q;
  bsa_pkg::entry_t  e_q;
  logic [MAP_W-1:0] occ_q;
  logic [MAP_W-1:0] fit_q, fit_d;

  // Result register.
  logic                         out_valid_q;
  bsa_pkg::status_e             out_status_q, res_status;
  logic [bsa_pkg::HANDLE_W-1:0] out_grant_q, res_grant;
  logic [MAP_W-1:0]             out_occ_q, res_occ;

  logic [MAP_W-1:0]        occ_rd;
  logic [MAP_W-1:0]        head_mask;
  logic                    search;
  logic                    s2_fire;
  logic                    map_we;
  logic [MAP_W-1:0]        new_map;
  logic [MAP_W-1:0]        e_mask;
  logic [MAP_W-1:0]        first_fit;
  logic [bsa_pkg::IDX_W-1:0] fit_idx;

  // The next item is taken only once the previous one has written its bitmap.
  assign pop_o   = !empty_i && !s2_valid_q;
  assign s2_fire = s2_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    occ_rd = '0;
    for (int p = 0; p < bsa_pkg::POOL_SLOTS; p++) begin
      if (head_i.pool == bsa_pkg::POOL_W'(p)) occ_rd = map_q[p];
    end
  end

  assign head_mask = run_mask(head_i.count);
  assign search    = (head_i.cmd == bsa_pkg::CMD_ALLOC) && (head_i.status == bsa_pkg::ST_OK);

  // A start position fits when the whole run lies below the pool limit and is free.
  always_comb begin
    for (int i = 0; i < MAP_W; i++) begin
      fit_d[i] = search &&
                 ((SUM_W'(i) + SUM_W'(head_i.count)) <= SUM_W'(head_i.limit)) &&
                 (((occ_rd >> i) & head_mask) == '0);
    end
  end

  // Lowest set bit of the fit vector, then its position.
  always_comb begin
    first_fit = fit_q & (~fit_q + MAP_W'(1));
    fit_idx   = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (first_fit[i]) fit_idx = fit_idx | bsa_pkg::IDX_W'(i);
    end
  end

  assign e_mask = run_mask(e_q.count);

  always_comb begin
    res_status = e_q.status;
    res_grant  = '0;
    res_occ    = occ_q;
    new_map    = occ_q;
    map_we     = 1'b0;
    case (e_q.status)
      bsa_pkg::ST_BADPOOL: begin
        res_occ = '0;
      end
      bsa_pkg::ST_OK: begin
        if (e_q.cmd == bsa_pkg::CMD_FREE) begin
          new_map = occ_q & ~(e_mask << e_q.index);
          map_we  = 1'b1;
          res_occ = new_map;
        end else if (|fit_q) begin
          new_map   = occ_q | (e_mask << fit_idx);
          map_we    = 1'b1;
          res_occ   = new_map;
          res_grant = {bsa_pkg::HPOOL_W'(e_q.pool), e_q.count, fit_idx};
        end else begin
          res_status = bsa_pkg::ST_NOSPACE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < bsa_pkg::POOL_SLOTS; p++) map_q[p] <= '0;
    end else begin
      if (pop_o) begin
        s2_valid_q <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s2_fire && map_we) map_q[e_q.pool] <= new_map;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      e_q   <= head_i;
      occ_q <= occ_rd;
      fit_q <= fit_d;
    end
    if (s2_fire) begin
      out_status_q <= res_status;
      out_grant_q  <= res_grant;
      out_occ_q    <= res_occ;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign grant_handle_o = out_grant_q;
  assign occupancy_o    = out_occ_q;

endmodule

// File: hw/rtl/bsa_checker.sv
// Port-level assertions for the bitmap slab allocator, bound to its top level.
`timescale 1ns / 1ps

module bsa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [2:0]                     status_i,
  input logic [bsa_pkg::HANDLE_W-1:0]   grant_handle_i,
  input logic [bsa_pkg::MAP_W-1:0]      occupancy_i
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(grant_handle_i) && $stable(occupancy_i))
    else $error("stalled result changed");

  // A failed request carries no handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != bsa_pkg::ST_OK |-> grant_handle_i == '0)
    else $error("handle on a failed request");

  // An invalid pool has no bitmap to show.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == bsa_pkg::ST_BADPOOL |-> occupancy_i == '0)
    else $error("bitmap shown for a bad pool");

  // A granted run is not empty and its first block is marked used in the bitmap returned with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == bsa_pkg::ST_OK && grant_handle_i != '0 |->
    grant_handle_i[11:6] != '0 && occupancy_i[grant_handle_i[5:0]])
    else $error("granted run not marked used");

endmodule

bind bitmap_slab_allocator_unit bsa_checker u_bsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_i       (status_o),
  .grant_handle_i (grant_handle_o),
  .occupancy_i    (occupancy_o)
);
